/* rtl/core/gds_pkg.sv */
package gds_pkg;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_STEP  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [2:0] REG_DIFF  = 3'd0;
	localparam logic [2:0] REG_DAMP  = 3'd1;
	localparam logic [2:0] REG_DT    = 3'd2;
	localparam logic [2:0] REG_SRCV  = 3'd3;
	localparam logic [2:0] REG_SRCI  = 3'd4;
	localparam logic [2:0] REG_DIMS  = 3'd5;

	localparam logic [1:0] DIMS_CHAIN = 2'd1;
	localparam logic [1:0] DIMS_GRID  = 2'd2;

	localparam int AMP_W = 32;
	localparam int COEF_W = 24;

	// Saturate a wide signed value to a 32-bit amplitude.
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/core/gds_ram.sv */
module gds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/gds_calc.sv */
module gds_calc import gds_pkg::*; (
	input  logic                     clk,
	input  logic                     start,
	input  logic signed [AMP_W-1:0]  center,
	input  logic signed [AMP_W+2:0]  nsum,
	input  logic [COEF_W-1:0]        diff_c,
	input  logic [COEF_W-1:0]        damp_c,
	input  logic [COEF_W-1:0]        dt_c,
	input  logic signed [AMP_W-1:0]  src_add,
	output logic [AMP_W:0]           result
);
	// Products floor to Q16.16 by an arithmetic shift of the full product.
	logic signed [AMP_W+2:0]  center_s1, nsum_s1, center_s2;
	logic signed [AMP_W-1:0]  src_s1, src_s2, src_s3;
	logic [COEF_W-1:0]        dt_s1, dt_s2;
	logic signed [63:0]       diff_s2, damp_s2, delta_s3, v_s4;
	logic signed [AMP_W+2:0]  center_s3;
	logic signed [31:0]       dhi;
	logic [39:0]              dlo;
	logic signed [63:0]       prod;

	// The time step product splits the difference into its upper part and its
	// low 16 bits, so the floored product stays exact within 64 bits.
	always_comb begin
		dhi  = 32'(delta_s3 >>> 16);
		dlo  = 40'(delta_s3[15:0]) * 40'(dt_s2);
		prod = 64'(dhi) * $signed({1'b0, dt_s2}) + $signed(64'(dlo[39:16]));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			center_s1 <= {{3{center[AMP_W-1]}}, center};
			nsum_s1   <= nsum;
			src_s1    <= src_add;
			dt_s1     <= dt_c;
		end
		// Stage 2: the two coefficient products.
		diff_s2   <= (64'(nsum_s1) * $signed({1'b0, diff_c})) >>> 16;
		damp_s2   <= (64'(center_s1) * $signed({1'b0, damp_c})) >>> 16;
		center_s2 <= center_s1;
		src_s2    <= src_s1;
		dt_s2     <= dt_s1;
		// Stage 3: difference of the two terms.
		delta_s3  <= diff_s2 - damp_s2;
		center_s3 <= center_s2;
		src_s3    <= src_s2;
		// Stage 4: time step product and accumulation.
		v_s4 <= 64'(center_s3) + prod + 64'(src_s3);
	end

	assign result = sat32(v_s4);
endmodule

/* rtl/core/grid_diffusion_step_unit.sv */
// A write's result is offered in the cycle after accept; an in-range read first passes ST_RD,
// where the registered RAM read lands. A step sweeps each cell in turn: ST_NB issues
// the center and four neighbor reads, ST_CALC runs the arithmetic pipeline and writes
// the scratch RAM, and a copy pass (ST_COPY, ST_COPYW) then copies it into the grid.
// One item is in work at a time; the input is refused until its result is taken.
// arst_n clears the control state, registers to their defaults and the grid by a
// clearing pass over every cell, during which no item is accepted.
module grid_diffusion_step_unit import gds_pkg::*; #(
	parameter int GRID_SIDE = 32,
	parameter int CELL_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // kind
	input  logic [47:0] s_tdata,   // cell_index[9:0], write_value[41:10], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], saturated[32], zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = AW + 1;
	localparam int SRC_RESET = (GRID_SIDE / 2) * GRID_SIDE + GRID_SIDE / 2;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_NB    = 4'd3;
	localparam logic [3:0] ST_CALC  = 4'd4;
	localparam logic [3:0] ST_COPY  = 4'd5;
	localparam logic [3:0] ST_COPYW = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	logic [3:0]  state_q;
	logic [23:0] diff_q, damp_q, dt_q;
	logic [31:0] srcv_q;
	logic [9:0]  srci_q;
	logic [1:0]  dims_q;
	logic [CW-1:0] cell_q;
	logic [CW-1:0] row_q, col_q;
	logic [2:0]  tap_q;
	logic [3:0]  wait_q;
	logic signed [31:0] center_q;
	logic signed [34:0] nsum_q;
	logic        sat_q;
	logic [31:0] rdv_q;
	logic        cpy_v_q;
	logic [AW-1:0] cpy_a_q;

	// Main grid RAM and the scratch RAM for the new values.
	logic          a_we, n_we;
	logic [AW-1:0] a_wa, a_ra, n_wa, n_ra;
	logic [31:0]   a_wd, a_rd, n_wd, n_rd;

	gds_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_amp (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	gds_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_next (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));

	logic [9:0]  in_cell;
	logic [31:0] in_wv;
	assign in_cell = s_tdata[9:0];
	assign in_wv   = s_tdata[41:10];
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {7'd0, sat_q, rdv_q};

	// Neighbor tap for the current cell: 0 center, 1 up, 2 down, 3 left, 4 right.
	// Row and column are counted along the sweep.
	logic [AW-1:0] ci;
	logic [CW-1:0] row, col;
	logic          tap_ok;
	logic [AW-1:0] tap_addr;
	assign ci  = cell_q[AW-1:0];
	assign row = row_q;
	assign col = col_q;

	always_comb begin
		tap_ok = 1'b0;
		tap_addr = ci;
		case (tap_q)
			3'd1: begin
				tap_ok = (dims_q == DIMS_GRID) && (row != '0);
				tap_addr = AW'(cell_q - CW'(GRID_SIDE));
			end
			3'd2: begin
				tap_ok = (dims_q == DIMS_GRID) && (32'(row) + 1 < GRID_SIDE)
					&& (32'(cell_q) + GRID_SIDE < CELL_COUNT);
				tap_addr = AW'(cell_q + CW'(GRID_SIDE));
			end
			3'd3: begin
				tap_ok = ((dims_q == DIMS_GRID) && (col != '0))
					|| ((dims_q == DIMS_CHAIN) && (cell_q != '0));
				tap_addr = AW'(cell_q - CW'(1));
			end
			3'd4: begin
				tap_ok = (32'(cell_q) + 1 < CELL_COUNT) && ((dims_q == DIMS_CHAIN)
					|| ((dims_q == DIMS_GRID) && (32'(col) + 1 < GRID_SIDE)));
				tap_addr = AW'(cell_q + CW'(1));
			end
			default: begin
				tap_ok = 1'b1;
				tap_addr = ci;
			end
		endcase
	end

	// Tap whose read data arrives this cycle.
	logic [2:0] ptap_q;
	logic       pok_q;

	// The pipeline starts once the last neighbor has been summed.
	logic [32:0] calc_res;
	logic        calc_start;
	assign calc_start = (state_q == ST_CALC) && (wait_q == 4'd4);

	gds_calc u_calc (
		.clk(clk), .start(calc_start), .center(center_q), .nsum(nsum_q),
		.diff_c(diff_q), .damp_c(damp_q), .dt_c(dt_q),
		.src_add((32'(srci_q) == 32'(cell_q) && 32'(srci_q) < CELL_COUNT)
			? srcv_q : 32'sd0),
		.result(calc_res));

	// Memory port steering.
	always_comb begin
		a_we = 1'b0; a_wa = ci; a_wd = '0; a_ra = tap_addr;
		n_we = 1'b0; n_wa = ci; n_wd = calc_res[31:0]; n_ra = ci;
		if (state_q == ST_CLEAR) begin
			a_we = 1'b1;
		end else if (state_q == ST_IDLE) begin
			a_ra = in_cell[AW-1:0];
			if (s_tvalid && s_tuser == KIND_WRITE && 32'(in_cell) < CELL_COUNT) begin
				a_we = 1'b1; a_wa = in_cell[AW-1:0]; a_wd = in_wv;
			end
		end else if (state_q == ST_CALC) begin
			n_we = (wait_q == 4'd0);
		end else if (state_q == ST_COPY || state_q == ST_COPYW) begin
			a_we = cpy_v_q; a_wa = cpy_a_q; a_wd = n_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cell_q <= '0; tap_q <= '0; wait_q <= '0;
			row_q <= '0; col_q <= '0;
			sat_q <= 1'b0; rdv_q <= '0; cpy_v_q <= 1'b0; cpy_a_q <= '0;
			ptap_q <= '0; pok_q <= 1'b0; nsum_q <= '0; center_q <= '0;
			diff_q <= 24'd6554; damp_q <= 24'd655; dt_q <= 24'd6554;
			srcv_q <= '0; srci_q <= 10'(SRC_RESET); dims_q <= DIMS_GRID;
		end else begin
			// Configuration writes.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIFF: diff_q <= cfg_wdata[23:0];
					REG_DAMP: damp_q <= cfg_wdata[23:0];
					REG_DT:   dt_q   <= cfg_wdata[23:0];
					REG_SRCV: srcv_q <= cfg_wdata;
					REG_SRCI: srci_q <= cfg_wdata[9:0];
					REG_DIMS: dims_q <= cfg_wdata[1:0];
					default: ;
				endcase
			end
			cpy_v_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					cell_q <= cell_q + 1'b1;
					if (32'(cell_q) == CELL_COUNT - 1) begin
						cell_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						rdv_q <= '0; sat_q <= 1'b0;
						cell_q <= CW'(in_cell);
						if (s_tuser == KIND_READ && 32'(in_cell) < CELL_COUNT) begin
							state_q <= ST_RD;
						end else if (s_tuser == KIND_STEP) begin
							cell_q <= '0; tap_q <= '0; pok_q <= 1'b0;
							row_q <= '0; col_q <= '0;
							nsum_q <= '0; state_q <= ST_NB;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RD: begin
					rdv_q <= a_rd;
					state_q <= ST_OUT;
				end
				ST_NB: begin
					// Accumulate the tap read in the previous cycle.
					if (pok_q) begin
						if (ptap_q == 3'd0) begin
							center_q <= a_rd;
						end else begin
							nsum_q <= nsum_q + 35'(signed'(a_rd)) - 35'(center_q);
						end
					end
					ptap_q <= tap_q;
					pok_q <= (tap_q != 3'd5) && tap_ok;
					tap_q <= tap_q + 1'b1;
					if (tap_q == 3'd5) begin
						wait_q <= 4'd4;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					wait_q <= wait_q - 1'b1;
					if (wait_q == 4'd0) begin
						sat_q <= sat_q | calc_res[32];
						tap_q <= '0; pok_q <= 1'b0; nsum_q <= '0;
						if (32'(col_q) == GRID_SIDE - 1) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						if (32'(cell_q) == CELL_COUNT - 1) begin
							cell_q <= '0;
							state_q <= ST_COPY;
						end else begin
							cell_q <= cell_q + 1'b1;
							state_q <= ST_NB;
						end
					end
				end
				ST_COPY: begin
					// Scratch read at cell_q lands next cycle and is written back.
					cpy_v_q <= 1'b1;
					cpy_a_q <= ci;
					if (32'(cell_q) == CELL_COUNT - 1) begin
						state_q <= ST_COPYW;
					end else begin
						cell_q <= cell_q + 1'b1;
					end
				end
				ST_COPYW: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// No input is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while result pending");
	// A read result reports no saturation.
	a_rdsat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (m_tvalid && !m_tdata[32]))
		else $error("read result flags saturation");
	// No grid write, from the clearing pass, an input write or the copy pass, falls outside the grid.
	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		a_we |-> (32'(a_wa) < CELL_COUNT))
		else $error("grid write out of range");
`endif
endmodule
